// ----- rtl/core/lpht_pkg.sv -----
// Shared constants, codes and types of the linear-probing hash table core.
package lpht_pkg;

    // Table geometry; SLOTS must be a power of two so the home slot is a bit slice.
    localparam int SLOTS      = 64;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int HASH_BITS  = 32;
    localparam int OCC_W      = 7;

    // Stream beat widths, padded up to whole bytes.
    localparam int IN_FIELDS_W  = 2 + KEY_BITS + HASH_BITS + VALUE_BITS;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + KEY_BITS + VALUE_BITS + OCC_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_W - OUT_FIELDS_W;

    // Request opcodes.
    typedef logic [1:0] op_t;
    localparam op_t OP_PUT = 2'd0;
    localparam op_t OP_GET = 2'd1;
    localparam op_t OP_DEL = 2'd2;

    // Slot states.
    typedef logic [1:0] slot_state_t;
    localparam slot_state_t SLOT_EMPTY = 2'd0;
    localparam slot_state_t SLOT_USED  = 2'd1;
    localparam slot_state_t SLOT_TOMB  = 2'd2;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_DONE = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    // One table entry as held in the slot memory.
    typedef struct packed {
        slot_state_t             state;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
    } slot_t;

    // Memory access from the probe controller.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_t            wr_data;
    } ram_req_t;

    // A decoded request beat.
    typedef struct packed {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      idx;
    } request_t;

    // One result beat.
    typedef struct packed {
        status_t               status;
        logic [KEY_BITS-1:0]   found_key;
        logic [VALUE_BITS-1:0] found_value;
        logic [OCC_W-1:0]      occupancy;
    } result_t;

endpackage

// ----- rtl/core/linear_probe_hash_table_core.sv -----
// Top level of the linear-probing hash table: stream ports, slot memory and output register.
//
//  Channel  Direction  Beat contents (lowest bits first)
//  s_       in         op[1:0], key[31:0], key_hash[31:0], value[31:0], zero pad
//  m_       out        status[1:0], found_key[31:0], found_value[31:0], occupancy[6:0], zero pad
//
// After acceptance a request probes P slots (1 to 64) before its result is loaded; the probe
// loop reads one slot per cycle from the slot memory. A request with an unused opcode skips
// the probe and goes straight to its result. A new request is accepted the cycle after the
// previous result moves into the output register, even while that result waits.
// Reset clears the slot valid flags; no clearing pass is needed.
// m_tvalid holds with stable data until m_tready; a stalled output stalls the next result.
module linear_probe_hash_table_core
    import lpht_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op, key, key_hash, value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, found_key, found_value, occupancy
);

    request_t   in_req;
    ram_req_t   ram_req;
    slot_t      rd_slot;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    // Unpack the input beat; the home slot is the hash modulo the slot count.
    always_comb begin
        in_req.op    = s_tdata[1:0];
        in_req.key   = s_tdata[2 +: KEY_BITS];
        in_req.idx   = s_tdata[2 + KEY_BITS +: IDX_W];
        in_req.value = s_tdata[2 + KEY_BITS + HASH_BITS +: VALUE_BITS];
    end

    lpht_probe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .ram_req   (ram_req),
        .rd_slot   (rd_slot),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    lpht_slot_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_slot (rd_slot)
    );

    // Output register decouples the result from the downstream stall.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res.occupancy, res.found_value,
                            res.found_key, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/lpht_slot_ram.sv -----
// Slot memory with one write and one registered read port, plus per-slot valid flags.
module lpht_slot_ram
    import lpht_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  ram_req_t req,
    output slot_t    rd_slot
);

    slot_t             mem [SLOTS];
    logic [SLOTS-1:0]  vld_reg;
    slot_t             rd_data_reg;
    logic              rd_vld_reg;

    // Valid flags make every slot read as empty right after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    // Entry storage; a read returns the data held before a same-cycle write.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // A slot never written reports the empty state.
    always_comb begin
        rd_slot = rd_data_reg;
        if (!rd_vld_reg) begin
            rd_slot.state = SLOT_EMPTY;
        end
    end

endmodule

// ----- rtl/core/lpht_probe_ctrl.sv -----
// Probe sequencer: walks the slots one per cycle and decides put, get and delete.
module lpht_probe_ctrl
    import lpht_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  request_t in_req,
    output ram_req_t ram_req,
    input  slot_t    rd_slot,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_CHECK  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    request_t         req_reg, req_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             have_tomb_reg, have_tomb_next;
    logic [IDX_W-1:0] tomb_reg, tomb_next;
    logic [OCC_W-1:0] live_reg, live_next;
    result_t          res_reg, res_next;

    logic             is_empty;
    logic             is_tomb;
    logic             key_hit;
    logic             last_probe;
    logic [IDX_W-1:0] put_target;
    logic [IDX_W-1:0] idx_inc;

    // Classification of the slot that came back from memory.
    always_comb begin
        is_empty   = (rd_slot.state == SLOT_EMPTY);
        is_tomb    = (rd_slot.state == SLOT_TOMB);
        key_hit    = (rd_slot.state == SLOT_USED) && (rd_slot.key == req_reg.key);
        last_probe = (cnt_reg == CNT_W'(SLOTS - 1));
        put_target = have_tomb_reg ? tomb_reg : req_reg.idx;
        idx_inc    = req_reg.idx + IDX_W'(1);
    end

    // Next-state and datapath decisions.
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        cnt_next       = cnt_reg;
        have_tomb_next = have_tomb_reg;
        tomb_next      = tomb_reg;
        live_next      = live_reg;
        res_next       = res_reg;
        ram_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next       = in_req;
                    cnt_next       = '0;
                    have_tomb_next = 1'b0;
                    res_next       = '{status: ST_MISS, found_key: '0,
                                       found_value: '0, occupancy: live_reg};
                    unique case (in_req.op)
                        OP_PUT, OP_GET, OP_DEL: state_next = S_ISSUE;
                        default:                state_next = S_RESULT;
                    endcase
                end
            end

            S_ISSUE: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = req_reg.idx;
                state_next      = S_CHECK;
            end

            S_CHECK: begin
                // Read the next slot ahead so a continuing probe finds it ready without another issue state.
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_inc;
                state_next      = S_RESULT;
                if (req_reg.op == OP_PUT) begin
                    priority if (is_empty || (last_probe && !key_hit &&
                                              (have_tomb_reg || is_tomb))) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = put_target;
                        ram_req.wr_data = '{state: SLOT_USED, key: req_reg.key,
                                            value: req_reg.value};
                        live_next       = live_reg + OCC_W'(1);
                        res_next.status = ST_DONE;
                    end else if (key_hit) begin
                        res_next.status = ST_MISS;
                    end else if (last_probe) begin
                        res_next.status = ST_FULL;
                    end else begin
                        state_next = S_CHECK;
                        if (is_tomb && !have_tomb_reg) begin
                            have_tomb_next = 1'b1;
                            tomb_next      = req_reg.idx;
                        end
                    end
                end else begin
                    priority if (is_empty) begin
                        res_next.status = ST_MISS;
                    end else if (key_hit) begin
                        res_next.status      = ST_DONE;
                        res_next.found_key   = rd_slot.key;
                        res_next.found_value = rd_slot.value;
                        if (req_reg.op == OP_DEL) begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = req_reg.idx;
                            ram_req.wr_data = '{state: SLOT_TOMB, key: rd_slot.key,
                                                value: rd_slot.value};
                            if (live_reg != '0) begin
                                live_next = live_reg - OCC_W'(1);
                            end
                        end
                    end else if (last_probe) begin
                        res_next.status = ST_MISS;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
                // Advance the probe when it keeps going.
                if (state_next == S_CHECK) begin
                    req_next.idx = idx_inc;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                res_next.occupancy = live_next;
            end

            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            have_tomb_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            have_tomb_reg <= have_tomb_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        tomb_reg <= tomb_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule
